>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the heap allocator.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising edge of clk outside reset.
`define FFHA_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must never hold, checked on the rising edge of clk outside reset.
`define FFHA_ASSERT_NEVER(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

>>> rtl/ffha_pkg.sv
// Package of the first-fit heap allocator: widths, status and op codes,
// datapath command codes and the controller/datapath interface structs. No dependencies.
package ffha_pkg;

    localparam int UNIT_W      = 12;
    localparam int BYTES_W     = 16;
    localparam int NEED_W      = 13;
    localparam int ST_W        = 2;
    localparam int UNIT_SHIFT  = 4;
    localparam int UNIT_BYTES  = 16;
    localparam int HDR_BYTES   = 16;
    localparam int MIN_UNITS   = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO     = 2'd2;
    localparam logic [ST_W-1:0] ST_BADFREE  = 2'd3;

    typedef logic [4:0] dp_op_t;

    localparam dp_op_t DP_NOP       = 5'd0;
    localparam dp_op_t DP_LOAD      = 5'd1;
    localparam dp_op_t DP_CLR       = 5'd2;
    localparam dp_op_t DP_SCAN_RD   = 5'd3;
    localparam dp_op_t DP_SCAN_CHK  = 5'd4;
    localparam dp_op_t DP_TAKE      = 5'd5;
    localparam dp_op_t DP_SPLIT1    = 5'd6;
    localparam dp_op_t DP_SPLIT2    = 5'd7;
    localparam dp_op_t DP_NX_RD     = 5'd8;
    localparam dp_op_t DP_NX_CHK    = 5'd9;
    localparam dp_op_t DP_PV_RD     = 5'd10;
    localparam dp_op_t DP_PV_CHK    = 5'd11;
    localparam dp_op_t DP_PV_HDR    = 5'd12;
    localparam dp_op_t DP_MWR       = 5'd13;
    localparam dp_op_t DP_FREE_RD   = 5'd14;
    localparam dp_op_t DP_FREE_CHK  = 5'd15;
    localparam dp_op_t DP_ERR_ZERO  = 5'd16;
    localparam dp_op_t DP_ERR_NOSPC = 5'd17;
    localparam dp_op_t DP_ERR_BAD   = 5'd18;
    localparam dp_op_t DP_OUT       = 5'd19;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic op_free;
        logic zero_req;
        logic scan_end;
        logic scan_stop;
        logic scan_fit;
        logic slack_small;
        logic nx_in;
        logic cur_nz;
        logic pv_ok;
        logic free_in_range;
        logic free_ok;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/ffha_dp.sv
// Datapath of the heap allocator: header and footer tag memories, scan and
// merge registers, and the result register. Depends on ffha_pkg.
module ffha_dp #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffha_pkg::dp_cmd_t               cmd,
    output ffha_pkg::dp_stat_t              stat,
    input  logic                            in_op,
    input  logic [ffha_pkg::BYTES_W-1:0]    in_req_bytes,
    input  logic [ffha_pkg::UNIT_W-1:0]     in_block_unit,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [ffha_pkg::UNIT_W-1:0]     out_result_unit,
    output logic [ffha_pkg::ST_W-1:0]       out_status
);
    import ffha_pkg::*;

    localparam int AW = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
    localparam int SW = $clog2(HEAP_UNITS + 1);
    localparam int PW = AW + 1;
    localparam int HW = SW + 2;
    localparam int XW = (PW > UNIT_W) ? PW : UNIT_W;
    localparam int CW = (SW > NEED_W) ? SW : NEED_W;

    localparam logic [PW-1:0] HEAP_P = PW'(HEAP_UNITS);
    localparam logic [SW-1:0] HEAP_S = SW'(HEAP_UNITS);
    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_UNITS);
    localparam logic [AW-1:0] LAST_A = AW'(HEAP_UNITS - 1);

    // Header word: size in units, start mark, allocated mark.
    logic [HW-1:0] hdr_mem [HEAP_UNITS];
    logic [SW-1:0] ftr_mem [HEAP_UNITS];

    logic [HW-1:0]     hdr_rd_reg;
    logic [SW-1:0]     ftr_rd_reg;

    logic              op_reg;
    logic              zero_reg;
    logic [NEED_W-1:0] need_reg;
    logic [UNIT_W-1:0] unit_reg;
    logic [PW-1:0]     cur_reg;
    logic [SW-1:0]     size_reg;
    logic [SW-1:0]     pn_reg;
    logic [PW-1:0]     p_reg;
    logic [UNIT_W-1:0] res_reg;
    logic [ST_W-1:0]   st_reg;
    logic [AW-1:0]     clr_reg;
    logic              out_valid_reg;
    logic [UNIT_W-1:0] out_unit_reg;
    logic [ST_W-1:0]   out_st_reg;

    logic                hdr_we, hdr_re, ftr_we, ftr_re;
    logic [AW-1:0]       hdr_wa, hdr_ra, ftr_wa, ftr_ra;
    logic [HW-1:0]       hdr_wd;
    logic [SW-1:0]       ftr_wd;

    logic [SW-1:0]       hq_size;
    logic                hq_start, hq_alloc;
    logic [BYTES_W:0]    req_sum;
    logic [NEED_W-1:0]   need_raw, need_in;
    logic [PW-1:0]       need_p, size_p, nx, end_size, end_need, pn_p, p_c;
    logic [SW-1:0]       rest_s;
    logic [XW-1:0]       unit_x, cur_x;
    logic                scan_fit, nx_free, pv_ok, prev_free;

    always_comb
    begin
        hq_size  = hdr_rd_reg[HW-1:2];
        hq_start = hdr_rd_reg[1];
        hq_alloc = hdr_rd_reg[0];

        req_sum  = {1'b0, in_req_bytes} + (BYTES_W+1)'(HDR_BYTES + UNIT_BYTES - 1);
        need_raw = NEED_W'(req_sum >> UNIT_SHIFT);
        need_in  = (need_raw < NEED_W'(MIN_UNITS)) ? NEED_W'(MIN_UNITS) : need_raw;

        need_p   = PW'(need_reg);
        size_p   = PW'(size_reg);
        nx       = cur_reg + size_p;
        end_size = cur_reg + size_p - PW'(1);
        end_need = cur_reg + need_p - PW'(1);
        rest_s   = size_reg - SW'(need_reg);
        pn_p     = PW'(ftr_rd_reg);
        p_c      = cur_reg - pn_p;
        unit_x   = XW'(unit_reg);
        cur_x    = XW'(cur_reg);

        scan_fit  = !hq_alloc && (CW'(need_reg) <= CW'(hq_size));
        nx_free   = hq_start && !hq_alloc;
        pv_ok     = (ftr_rd_reg != '0) && (pn_p <= cur_reg);
        prev_free = hq_start && !hq_alloc && (hq_size == pn_reg);
    end

    always_comb
    begin
        stat.clr_last      = (clr_reg == LAST_A);
        stat.op_free       = (op_reg == OP_FREE);
        stat.zero_req      = zero_reg;
        stat.scan_end      = (cur_reg >= HEAP_P);
        stat.scan_stop     = (hq_size == '0);
        stat.scan_fit      = scan_fit;
        stat.slack_small   = ((CW'(size_reg) - CW'(need_reg)) < CW'(MIN_UNITS));
        stat.nx_in         = (nx < HEAP_P);
        stat.cur_nz        = (cur_reg != '0);
        stat.pv_ok         = pv_ok;
        stat.free_in_range = (unit_x < HEAP_X);
        stat.free_ok       = hq_start && hq_alloc;
        stat.out_free      = !out_valid_reg || out_ready;
    end

    // Memory port selection for each command.
    always_comb
    begin
        hdr_we = 1'b0;
        hdr_wa = '0;
        hdr_wd = '0;
        hdr_re = 1'b0;
        hdr_ra = '0;
        ftr_we = 1'b0;
        ftr_wa = '0;
        ftr_wd = '0;
        ftr_re = 1'b0;
        ftr_ra = '0;
        case (cmd.op)
            DP_CLR:
            begin
                hdr_we = 1'b1;
                hdr_wa = clr_reg;
                hdr_wd = (clr_reg == '0) ? {HEAP_S, 1'b1, 1'b0} : '0;
                ftr_we = 1'b1;
                ftr_wa = clr_reg;
                ftr_wd = (clr_reg == LAST_A) ? HEAP_S : '0;
            end
            DP_SCAN_RD:
            begin
                hdr_re = 1'b1;
                hdr_ra = cur_reg[AW-1:0];
            end
            DP_TAKE:
            begin
                hdr_we = 1'b1;
                hdr_wa = cur_reg[AW-1:0];
                hdr_wd = {size_reg, 1'b1, 1'b1};
                ftr_we = 1'b1;
                ftr_wa = end_size[AW-1:0];
                ftr_wd = size_reg;
            end
            DP_SPLIT1:
            begin
                hdr_we = 1'b1;
                hdr_wa = cur_reg[AW-1:0];
                hdr_wd = {SW'(need_reg), 1'b1, 1'b1};
                ftr_we = 1'b1;
                ftr_wa = end_need[AW-1:0];
                ftr_wd = SW'(need_reg);
            end
            DP_SPLIT2:
            begin
                hdr_we = 1'b1;
                hdr_wa = AW'(cur_reg + need_p);
                hdr_wd = {rest_s, 1'b1, 1'b0};
                ftr_we = 1'b1;
                ftr_wa = end_size[AW-1:0];
                ftr_wd = rest_s;
            end
            DP_NX_RD:
            begin
                hdr_re = 1'b1;
                hdr_ra = nx[AW-1:0];
            end
            DP_NX_CHK:
            begin
                hdr_we = nx_free;
                hdr_wa = nx[AW-1:0];
                hdr_wd = '0;
            end
            DP_PV_RD:
            begin
                ftr_re = 1'b1;
                ftr_ra = AW'(cur_reg - PW'(1));
            end
            DP_PV_CHK:
            begin
                hdr_re = pv_ok;
                hdr_ra = p_c[AW-1:0];
            end
            DP_PV_HDR:
            begin
                hdr_we = prev_free;
                hdr_wa = cur_reg[AW-1:0];
                hdr_wd = '0;
            end
            DP_MWR:
            begin
                hdr_we = 1'b1;
                hdr_wa = cur_reg[AW-1:0];
                hdr_wd = {size_reg, 1'b1, 1'b0};
                ftr_we = 1'b1;
                ftr_wa = end_size[AW-1:0];
                ftr_wd = size_reg;
            end
            DP_FREE_RD:
            begin
                hdr_re = 1'b1;
                hdr_ra = unit_x[AW-1:0];
            end
            default:
            begin
                hdr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[hdr_wa] <= hdr_wd;
        end
        if (hdr_re)
        begin
            hdr_rd_reg <= hdr_mem[hdr_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ftr_we)
        begin
            ftr_mem[ftr_wa] <= ftr_wd;
        end
        if (ftr_re)
        begin
            ftr_rd_reg <= ftr_mem[ftr_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == DP_CLR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.op == DP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                op_reg   <= in_op;
                zero_reg <= (in_req_bytes == '0);
                need_reg <= need_in;
                unit_reg <= in_block_unit;
                cur_reg  <= '0;
                res_reg  <= '0;
                st_reg   <= ST_OK;
            end
            DP_SCAN_CHK:
            begin
                if (scan_fit)
                begin
                    size_reg <= hq_size;
                end
                else
                begin
                    cur_reg <= cur_reg + PW'(hq_size);
                end
            end
            DP_TAKE, DP_SPLIT1:
            begin
                res_reg <= cur_x[UNIT_W-1:0];
            end
            DP_SPLIT2:
            begin
                cur_reg  <= cur_reg + need_p;
                size_reg <= rest_s;
            end
            DP_NX_CHK:
            begin
                if (nx_free)
                begin
                    size_reg <= size_reg + hq_size;
                end
            end
            DP_PV_CHK:
            begin
                pn_reg <= ftr_rd_reg;
                p_reg  <= p_c;
            end
            DP_PV_HDR:
            begin
                if (prev_free)
                begin
                    cur_reg  <= p_reg;
                    size_reg <= size_reg + pn_reg;
                end
            end
            DP_MWR:
            begin
                if (op_reg == OP_FREE)
                begin
                    res_reg <= cur_x[UNIT_W-1:0];
                end
            end
            DP_FREE_RD:
            begin
                cur_reg <= unit_x[PW-1:0];
            end
            DP_FREE_CHK:
            begin
                size_reg <= hq_size;
            end
            DP_ERR_ZERO:
            begin
                st_reg <= ST_ZERO;
            end
            DP_ERR_NOSPC:
            begin
                st_reg <= ST_NOSPACE;
            end
            DP_ERR_BAD:
            begin
                st_reg <= ST_BADFREE;
            end
            DP_OUT:
            begin
                out_unit_reg <= res_reg;
                out_st_reg   <= st_reg;
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign out_result_unit = out_unit_reg;
    assign out_status      = out_st_reg;

endmodule

>>> rtl/ffha_ctrl.sv
// Controller of the heap allocator: sequences the clearing pass, the
// first-fit scan, split and merge steps. Depends on ffha_pkg.
module ffha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffha_pkg::dp_stat_t  stat,
    output ffha_pkg::dp_cmd_t   cmd
);
    import ffha_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_FIT      = 4'd5;
    localparam logic [3:0] S_SPLIT2   = 4'd6;
    localparam logic [3:0] S_FREE     = 4'd7;
    localparam logic [3:0] S_FREE_CHK = 4'd8;
    localparam logic [3:0] S_NX       = 4'd9;
    localparam logic [3:0] S_NX_CHK   = 4'd10;
    localparam logic [3:0] S_PV       = 4'd11;
    localparam logic [3:0] S_PV_CHK   = 4'd12;
    localparam logic [3:0] S_PV_HDR   = 4'd13;
    localparam logic [3:0] S_MWR      = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.op_free)
                begin
                    state_next = S_FREE;
                end
                else if (stat.zero_req)
                begin
                    cmd.op     = DP_ERR_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.op     = DP_ERR_NOSPC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_SCAN_RD;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.scan_stop)
                begin
                    cmd.op     = DP_ERR_NOSPC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_SCAN_CHK;
                    state_next = stat.scan_fit ? S_FIT : S_SCAN;
                end
            end
            S_FIT:
            begin
                if (stat.slack_small)
                begin
                    cmd.op     = DP_TAKE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_SPLIT1;
                    state_next = S_SPLIT2;
                end
            end
            S_SPLIT2:
            begin
                cmd.op     = DP_SPLIT2;
                state_next = S_NX;
            end
            S_FREE:
            begin
                if (stat.free_in_range)
                begin
                    cmd.op     = DP_FREE_RD;
                    state_next = S_FREE_CHK;
                end
                else
                begin
                    cmd.op     = DP_ERR_BAD;
                    state_next = S_DONE;
                end
            end
            S_FREE_CHK:
            begin
                if (stat.free_ok)
                begin
                    cmd.op     = DP_FREE_CHK;
                    state_next = S_NX;
                end
                else
                begin
                    cmd.op     = DP_ERR_BAD;
                    state_next = S_DONE;
                end
            end
            S_NX:
            begin
                if (stat.nx_in)
                begin
                    cmd.op     = DP_NX_RD;
                    state_next = S_NX_CHK;
                end
                else
                begin
                    state_next = S_PV;
                end
            end
            S_NX_CHK:
            begin
                cmd.op     = DP_NX_CHK;
                state_next = S_PV;
            end
            S_PV:
            begin
                if (stat.cur_nz)
                begin
                    cmd.op     = DP_PV_RD;
                    state_next = S_PV_CHK;
                end
                else
                begin
                    state_next = S_MWR;
                end
            end
            S_PV_CHK:
            begin
                cmd.op     = DP_PV_CHK;
                state_next = stat.pv_ok ? S_PV_HDR : S_MWR;
            end
            S_PV_HDR:
            begin
                cmd.op     = DP_PV_HDR;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                cmd.op     = DP_MWR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/first_fit_heap_allocator.sv
// First-fit heap allocator, top level: joins the controller and the datapath
// to the stream ports. Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
// The block manages a heap of HEAP_UNITS units of 16 bytes. Every block of
// the heap carries a header tag on its first unit (size, start and allocated
// marks) and a footer tag on its last unit (size). An allocate transfer rounds
// the request to max(2, ceil((req_bytes + 16) / 16)) units, walks the blocks
// from unit 0 and takes the first free block that is large enough, splitting
// off the rest as a free block (merged with a free successor) when at least
// two units remain. A free transfer clears the allocated mark and merges the
// block with free neighbors through the boundary tags. Each input transfer
// gives exactly one result transfer. After reset the block first clears both
// tag memories, one unit per cycle, and holds s_tready low meanwhile. Then
// items are handled one at a time; the cost is set by the single read port
// of the header memory, whose registered read makes each block visited take
// a read step and a check step. A result waits in the output register, and
// s_tready returns in the cycle it is loaded, so the next item can be taken
// while the result is still pending; an item that finishes while the
// previous result is still unaccepted waits for it.
module first_fit_heap_allocator #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: req_bytes [15:0], block_unit [27:16], zero fill [31:28].
    input  logic [ffha_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: op [0] (0 allocate, 1 free).
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: result_unit [11:0], zero fill [15:12].
    output logic [ffha_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: status [1:0] (0 ok, 1 no space, 2 zero request, 3 bad free).
    output logic [ffha_pkg::ST_W-1:0]         m_tuser
);
    import ffha_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [UNIT_W-1:0]  result_unit;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffha_dp #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser[0]),
        .in_req_bytes    (s_tdata[BYTES_W-1:0]),
        .in_block_unit   (s_tdata[BYTES_W+UNIT_W-1:BYTES_W]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_result_unit (result_unit),
        .out_status      (m_tuser)
    );

    // The result unit sits in the low bits; the upper bits are zero fill.
    assign m_tdata = {{(M_TDATA_W-UNIT_W){1'b0}}, result_unit};

endmodule

>>> rtl/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffha_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ffha_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [ffha_pkg::ST_W-1:0]         m_tuser
);
    import ffha_pkg::*;

    logic                        out_stall;
    logic                        in_xfer;
    logic                        out_err;
    logic [M_TDATA_W+ST_W-1:0]   out_word;

    assign out_stall = m_tvalid && !m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_err   = m_tvalid && (m_tuser != ST_OK);
    assign out_word  = {m_tdata, m_tuser};

    // A stalled result keeps its value until it is taken.
    `FFHA_ASSERT_CLK(a_out_hold, out_stall |=> m_tvalid && $stable(out_word), "held result moved")

    // Items are handled one at a time: an accepted item closes the input.
    `FFHA_ASSERT_CLK(a_one_item, in_xfer |=> !s_tready, "input stayed open after a transfer")

    // Every failed request reports unit zero.
    `FFHA_ASSERT_NEVER(a_err_unit, out_err && (m_tdata != '0), "failed request with a nonzero unit")

    // A new result appears only as the block returns to idle.
    `FFHA_ASSERT_CLK(a_out_idle, $rose(m_tvalid) |-> s_tready, "result loaded while still busy")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

>>> tb/tb_first_fit_heap_allocator.sv
// Self-checking testbench for first_fit_heap_allocator: drives allocate and free
// transfers with random idling on both stream sides and checks every result.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
module tb_first_fit_heap_allocator;

    import ffha_pkg::*;

    // The heap size must match the DUT parameter. Every block in the
    // predictor's copy of the heap is at most this many units long.
    localparam int HEAP_UNITS   = 4096;
    localparam int RANDOM_ITEMS = 950;
    // Upper bound on cycles without any transfer. It must cover the clearing pass
    // after reset, and a worst-case scan over 2048 blocks plus the longest stall
    // on the result side.
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic               op;
        logic [BYTES_W-1:0] req_bytes;
        logic [UNIT_W-1:0]  block_unit;
    } heap_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic [ST_W-1:0]   status;
    } heap_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;

    first_fit_heap_allocator #(
        .HEAP_UNITS(HEAP_UNITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor's copy of the boundary tags. A header holds the block size in
    // units plus start and allocated marks; a footer on the last unit of a
    // block holds its size again, so a free can find its predecessor.
    logic [12:0] hdr_size  [HEAP_UNITS];
    logic        hdr_start [HEAP_UNITS];
    logic        hdr_used  [HEAP_UNITS];
    logic [12:0] foot_size [HEAP_UNITS];

    heap_req_t        request_q[$];       // requests waiting for the driver
    heap_result_t     heap_outcomes[$];   // predicted results, oldest first
    logic [UNIT_W-1:0] live_blocks[$];    // start units currently allocated
    logic [UNIT_W-1:0] released_blocks[$];// recently freed starts, for double frees

    int  queued_items   = 0;
    int  accepted_items = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  idle_cycles    = 0;
    bit  in_taken       = 1'b0;   // input transfer at the last rising edge

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic void put_block(input int s, input int n, input logic used);
        hdr_size[s]      = n[12:0];
        hdr_start[s]     = 1'b1;
        hdr_used[s]      = used;
        foot_size[s+n-1] = n[12:0];
    endfunction

    function automatic void clear_header(input int s);
        hdr_size[s]  = '0;
        hdr_start[s] = 1'b0;
        hdr_used[s]  = 1'b0;
    endfunction

    // Merges the free block at s with a free successor and a free
    // predecessor, and returns the start of the merged block.
    function automatic logic [UNIT_W-1:0] coalesce(input int s);
        int n;
        int nx;
        int pn;
        n  = hdr_size[s];
        nx = s + n;
        if (nx < HEAP_UNITS && hdr_start[nx] && !hdr_used[nx])
        begin
            n += hdr_size[nx];
            clear_header(nx);
        end
        if (s > 0)
        begin
            pn = foot_size[s-1];
            // The footer left of s is trusted only if it leads back to a
            // free block header of the same size.
            if (pn > 0 && pn <= s && hdr_start[s-pn] && !hdr_used[s-pn]
                && hdr_size[s-pn] == pn)
            begin
                clear_header(s);
                s = s - pn;
                n += pn;
            end
        end
        put_block(s, n, 1'b0);
        return s[UNIT_W-1:0];
    endfunction

    // Applies one request to the predicted heap and returns its result.
    function automatic heap_result_t apply_to_heap(input heap_req_t rq);
        heap_result_t r;
        int need;
        int u;
        int n;
        bit found;
        r.unit   = '0;
        r.status = ST_OK;
        if (rq.op == OP_ALLOC)
        begin
            if (rq.req_bytes == 0)
                r.status = ST_ZERO;
            else
            begin
                need = (int'(rq.req_bytes) + HDR_BYTES + UNIT_BYTES - 1) / UNIT_BYTES;
                if (need < MIN_UNITS)
                    need = MIN_UNITS;
                // First fit: walk the headers from unit 0.
                u = 0;
                found = 1'b0;
                while (u < HEAP_UNITS && hdr_size[u] != 0 && !found)
                begin
                    if (!hdr_used[u] && need <= hdr_size[u])
                        found = 1'b1;
                    else
                        u += hdr_size[u];
                end
                if (found)
                begin
                    n = hdr_size[u];
                    if (n - need < MIN_UNITS)
                        put_block(u, n, 1'b1);   // too little slack to split
                    else
                    begin
                        put_block(u, need, 1'b1);
                        put_block(u + need, n - need, 1'b0);
                        void'(coalesce(u + need));
                    end
                    r.unit = u[UNIT_W-1:0];
                end
                else
                    r.status = ST_NOSPACE;
            end
        end
        else
        begin
            u = rq.block_unit;
            if (u < HEAP_UNITS && hdr_start[u] && hdr_used[u])
            begin
                put_block(u, hdr_size[u], 1'b0);
                r.unit = coalesce(u);
            end
            else
                r.status = ST_BADFREE;
        end
        return r;
    endfunction

    // Idle length for either side: mostly short, a few long, and every fourth
    // stretch of 128 transfers runs with no idling at all.
    function automatic int draw_idle(input int idx);
        int r;
        if ((idx / 128) % 4 == 3)
            return 0;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 16);
        else
            return $urandom_range(20, 80);
    endfunction

    task automatic queue_request(input logic op, input logic [BYTES_W-1:0] bytes,
                                 input logic [UNIT_W-1:0] unit);
        heap_req_t rq;
        rq.op         = op;
        rq.req_bytes  = bytes;
        rq.block_unit = unit;
        request_q.push_back(rq);
        queued_items++;
    endtask

    // Input driver: presents the next queued request at the falling edge and
    // holds it until a transfer, then idles for a random gap.
    int in_gap  = 0;
    int in_sent = 0;

    always @(negedge clk)
    begin : request_driver
        heap_req_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                nxt = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0000, nxt.block_unit, nxt.req_bytes};
                s_tuser  <= nxt.op;
                in_gap   = draw_idle(in_sent);
                in_sent++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure: ready is dropped for a random stall, then
    // raised for a random spell before the next draw.
    int ready_hold = 0;

    always @(negedge clk)
    begin : result_sink
        int stall;
        if (ready_hold > 0)
            ready_hold--;
        else if (m_tready)
        begin
            stall = draw_idle(results_seen);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                ready_hold = stall - 1;
            end
        end
        else
        begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end
    end

    // Monitor: at each rising edge, an input transfer is run through the
    // predictor, and a result transfer is checked against the oldest
    // prediction. The watchdog closes the block.
    always @(posedge clk)
    begin : monitor
        heap_req_t    rq;
        heap_result_t want;
        heap_result_t got;
        bit           out_taken;
        int           i;
        bit           hit;
        in_taken = rst_n && s_tvalid && s_tready;
        out_taken = rst_n && m_tvalid && m_tready;
        if (in_taken)
        begin
            rq.op         = s_tuser[0];
            rq.req_bytes  = s_tdata[BYTES_W-1:0];
            rq.block_unit = s_tdata[BYTES_W+UNIT_W-1:BYTES_W];
            want = apply_to_heap(rq);
            heap_outcomes.push_back(want);
            accepted_items++;
            // Keep the list of live blocks in step so the stimulus can
            // free real allocations.
            if (want.status == ST_OK && rq.op == OP_ALLOC)
                live_blocks.push_back(want.unit);
            else if (want.status == ST_OK)
            begin
                hit = 1'b0;
                for (i = 0; i < live_blocks.size() && !hit; i++)
                begin
                    if (live_blocks[i] == rq.block_unit)
                    begin
                        live_blocks.delete(i);
                        hit = 1'b1;
                    end
                end
                released_blocks.push_back(rq.block_unit);
                if (released_blocks.size() > 16)
                    void'(released_blocks.pop_front());
            end
        end
        if (out_taken)
        begin
            results_seen++;
            got.unit   = m_tdata[UNIT_W-1:0];
            got.status = m_tuser;
            if (heap_outcomes.size() == 0)
                report_mismatch($sformatf("unexpected result unit %0d status %0d",
                                          got.unit, got.status));
            else
            begin
                want = heap_outcomes.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                              results_seen, got.status, want.status));
                if (got.unit !== want.unit)
                    report_mismatch($sformatf("result %0d: unit %0d, expected %0d",
                                              results_seen, got.unit, want.unit));
            end
        end
        if (!rst_n || in_taken || out_taken)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("first_fit_heap_allocator regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int k;
        int pick;
        int sub;
        int size_sel;
        int bytes;

        // The predictor starts from the same heap as the block after its
        // clearing pass: one free block over the whole heap.
        for (k = 0; k < HEAP_UNITS; k++)
        begin
            clear_header(k);
            foot_size[k] = '0;
        end
        put_block(0, HEAP_UNITS, 1'b0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Request sizes at the edges of the rounding, a heap
        // filled by one block, frees that merge left, right and both ways,
        // bad frees, and a fit with too little slack to split.
        queue_request(OP_ALLOC, 16'd0, 12'hFFF);      // zero request
        queue_request(OP_ALLOC, 16'hFFFF, 12'd0);     // needs more than the heap
        queue_request(OP_ALLOC, 16'd65521, 12'd0);    // one unit too many
        queue_request(OP_ALLOC, 16'd65520, 12'd0);    // exactly the whole heap
        queue_request(OP_ALLOC, 16'd1, 12'd0);        // heap full
        queue_request(OP_FREE, 16'hFFFF, 12'd0);
        queue_request(OP_FREE, 16'd0, 12'd0);         // already free
        queue_request(OP_ALLOC, 16'd1, 12'd0);        // minimum block of two units
        queue_request(OP_ALLOC, 16'd16, 12'd0);
        queue_request(OP_ALLOC, 16'd17, 12'd0);       // rounds up to three units
        queue_request(OP_FREE, 16'd0, 12'd1);         // inside a block
        queue_request(OP_FREE, 16'd0, 12'd2);         // both neighbors allocated
        queue_request(OP_ALLOC, 16'd16, 12'd0);       // exact fit in the hole
        queue_request(OP_FREE, 16'd0, 12'd0);
        queue_request(OP_FREE, 16'd0, 12'd2);         // merges with predecessor
        queue_request(OP_FREE, 16'd0, 12'd4);         // merges both ways
        queue_request(OP_FREE, 16'd0, 12'hFFF);       // last unit, not a block start
        queue_request(OP_ALLOC, 16'd32, 12'd0);
        queue_request(OP_ALLOC, 16'd1, 12'd0);
        queue_request(OP_FREE, 16'd0, 12'd0);         // leaves a three-unit hole
        queue_request(OP_ALLOC, 16'd1, 12'd0);        // takes the hole whole
        queue_request(OP_FREE, 16'd0, 12'd3);         // merges with successor
        queue_request(OP_FREE, 16'd0, 12'd0);
        queue_request(OP_ALLOC, 16'd65505, 12'd0);    // smallest request that needs every unit
        queue_request(OP_FREE, 16'd0, 12'd0);

        // Random part. Mostly allocations and frees of live blocks, so the
        // heap fragments and first fit has to skip blocks; a small share is
        // noise: zero requests, frees of random units and double frees.
        // The unused field of each request carries random bits.
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            while (request_q.size() >= 2)
                @(posedge clk);
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                sub = $urandom_range(2);
                if (sub == 0)
                    queue_request(OP_ALLOC, 16'd0, UNIT_W'($urandom));
                else if (sub == 1 || released_blocks.size() == 0)
                    queue_request(OP_FREE, BYTES_W'($urandom), UNIT_W'($urandom));
                else
                    queue_request(OP_FREE, BYTES_W'($urandom),
                        released_blocks[$urandom_range(released_blocks.size() - 1)]);
            end
            else if (live_blocks.size() > 0 && pick < (live_blocks.size() > 40 ? 75 : 42))
                queue_request(OP_FREE, BYTES_W'($urandom),
                              live_blocks[$urandom_range(live_blocks.size() - 1)]);
            else
            begin
                // Mostly small blocks keep the scans short; a few large and
                // oversized requests push the heap toward no space.
                size_sel = $urandom_range(99);
                if (size_sel < 75)
                    bytes = $urandom_range(1, 256);
                else if (size_sel < 95)
                    bytes = $urandom_range(257, 4096);
                else
                    bytes = $urandom_range(4097, 65535);
                queue_request(OP_ALLOC, bytes[BYTES_W-1:0], UNIT_W'($urandom));
            end
        end

        // Wait for every request to be taken and every result to arrive,
        // then leave a short window for stray results.
        while (accepted_items != queued_items)
            @(posedge clk);
        while (heap_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("first_fit_heap_allocator regression: pass");
        else
            $display("first_fit_heap_allocator regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_dp.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
